/* design/cscos_pkg.sv */
// Package for the CORDIC sine and cosine block: vector type, constants and arctangent table.
package cscos_pkg;

  // Width of the angle and of both vector components.
  localparam int unsigned DW = 32;
  // Width of the residual angle in radians, signed 2.30 with headroom.
  localparam int unsigned ZW = 33;

  localparam logic [DW-1:0] QUARTER_TURN = 32'h4000_0000;
  localparam logic [DW-1:0] HALF_TURN    = 32'h8000_0000;
  localparam logic [DW-1:0] TAU_Q28      = 32'h6487_ED51;
  localparam logic [DW-1:0] GAIN_K       = 32'h26DD_3B6A;

  // Arctangent of 2^-i in radians, signed 2.30 format.
  localparam logic [DW-1:0] ATAN_TAB [32] = '{
    32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6,
    32'h03FEAB76, 32'h01FFD55B, 32'h00FFFAAA, 32'h007FFF55,
    32'h003FFFEA, 32'h001FFFFD, 32'h000FFFFF, 32'h0007FFFF,
    32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF, 32'h00007FFF,
    32'h00003FFF, 32'h00001FFF, 32'h00000FFF, 32'h000007FF,
    32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F,
    32'h0000003F, 32'h0000001F, 32'h0000000F, 32'h00000008,
    32'h00000004, 32'h00000002, 32'h00000001, 32'h00000000
  };

  // State that one pipeline stage hands to the next.
  typedef struct packed {
    logic [DW-1:0] x;
    logic [DW-1:0] y;
    logic [ZW-1:0] z;
    logic          fold;
  } cscos_vec_t;

endpackage

/* design/cscos_in_if.sv */
// Valid/ready channel that carries one angle per beat.
interface cscos_in_if;
  import cscos_pkg::*;

  logic                 valid;
  logic                 ready;
  logic signed [DW-1:0] angle;

  modport source (output valid, output angle, input ready);
  modport sink   (input valid, input angle, output ready);
endinterface

/* design/cscos_out_if.sv */
// Valid/ready channel that carries one cosine and sine pair per beat.
interface cscos_out_if;
  import cscos_pkg::*;

  logic                 valid;
  logic                 ready;
  logic signed [DW-1:0] cosine;
  logic signed [DW-1:0] sine;

  modport source (output valid, output cosine, output sine, input ready);
  modport sink   (input valid, input cosine, input sine, output ready);
endinterface

/* design/cscos_prep.sv */
// Front stage: quadrant fold, conversion of the turn angle to radians and start vector.
module cscos_prep
  import cscos_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  output logic                 ready_o,
  input  logic signed [DW-1:0] angle_i,
  output logic                 valid_o,
  input  logic                 ready_i,
  output cscos_vec_t           vec_o
);

  logic                   valid_q, valid_d;
  cscos_vec_t             vec_q, vec_d;
  logic                   fold;
  logic signed [DW-1:0]   folded;
  logic signed [2*DW-1:0] product;

  // The stage takes a beat when it is empty or its content moves on.
  assign ready_o = !valid_q || ready_i;

  // Angles strictly beyond a quarter turn are moved by half a turn.
  always_comb begin
    fold    = (angle_i > $signed(QUARTER_TURN)) || (angle_i < -$signed(QUARTER_TURN));
    folded  = fold ? (angle_i + $signed(HALF_TURN)) : angle_i;
    product = folded * $signed(TAU_Q28);
    vec_d.x    = GAIN_K;
    vec_d.y    = '0;
    vec_d.z    = product[ZW+29:30];
    vec_d.fold = fold;
    valid_d    = ready_o ? valid_i : valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      vec_q <= vec_d;
    end
  end

  assign valid_o = valid_q;
  assign vec_o   = vec_q;

endmodule

/* design/cscos_cell.sv */
// One rotation-mode CORDIC step with its own pipeline register and handshake.
module cscos_cell
  import cscos_pkg::*;
#(
  parameter int SHIFT = 0
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       valid_i,
  output logic       ready_o,
  input  cscos_vec_t vec_i,
  output logic       valid_o,
  input  logic       ready_i,
  output cscos_vec_t vec_o
);

  localparam logic [DW-1:0] ATAN = ATAN_TAB[SHIFT[4:0]];

  logic          valid_q, valid_d;
  cscos_vec_t    vec_q, vec_d;
  logic [DW-1:0] dx, dy;
  logic [ZW-1:0] da;

  assign ready_o = !valid_q || ready_i;

  // Rotate toward zero residual angle; a non-negative residual turns counterclockwise.
  always_comb begin
    dx = $unsigned($signed(vec_i.y) >>> SHIFT);
    dy = $unsigned($signed(vec_i.x) >>> SHIFT);
    da = {{(ZW-DW){1'b0}}, ATAN};
    vec_d.fold = vec_i.fold;
    if (!vec_i.z[ZW-1]) begin
      vec_d.x = vec_i.x - dx;
      vec_d.y = vec_i.y + dy;
      vec_d.z = vec_i.z - da;
    end else begin
      vec_d.x = vec_i.x + dx;
      vec_d.y = vec_i.y - dy;
      vec_d.z = vec_i.z + da;
    end
    valid_d = ready_o ? valid_i : valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      vec_q <= vec_d;
    end
  end

  assign valid_o = valid_q;
  assign vec_o   = vec_q;

endmodule

/* design/cordic_sine_cosine.sv */
// Sine and cosine of a binary angle: a front stage, a chain of CORDIC cells and an output register.
//
// Each beat on in_i carries a signed 32-bit angle in which 2^32 is one full turn; each beat on
// out_o carries its cosine and sine in signed 2.30 format, in the order the angles came in. One
// angle is taken per clock cycle while out_o is not stalled. An angle passes the register after
// the quadrant fold and the radian conversion multiply, the register in each of the STEPS CORDIC
// cells and the output register that applies the sign of a folded angle. Every stage has its own
// valid bit, so empty stages keep filling while a result waits on out_o, and the pipeline holds
// up to STEPS + 2 results before in_i.ready drops. The gain constant is fixed for 31 steps.
module cordic_sine_cosine
  import cscos_pkg::*;
#(
  parameter int STEPS = 31
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  cscos_in_if.sink   in_i,
  cscos_out_if.source out_o
);

  logic       link_valid [STEPS+1];
  logic       link_ready [STEPS+1];
  cscos_vec_t link_vec   [STEPS+1];

  logic                 out_valid_q, out_valid_d;
  logic signed [DW-1:0] cosine_q, sine_q;
  logic                 out_load;

  // Fold and conversion to radians.
  cscos_prep u_prep (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_i.valid),
    .ready_o (in_i.ready),
    .angle_i (in_i.angle),
    .valid_o (link_valid[0]),
    .ready_i (link_ready[0]),
    .vec_o   (link_vec[0])
  );

  // Chain of CORDIC cells, cell i shifts by i.
  for (genvar i = 0; i < STEPS; i++) begin : g_cell
    cscos_cell #(
      .SHIFT (i)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (link_valid[i]),
      .ready_o (link_ready[i]),
      .vec_i   (link_vec[i]),
      .valid_o (link_valid[i+1]),
      .ready_i (link_ready[i+1]),
      .vec_o   (link_vec[i+1])
    );
  end

  // Output register; a folded angle gets both components negated.
  assign out_load          = !out_valid_q || out_o.ready;
  assign link_ready[STEPS] = out_load;
  assign out_valid_d       = out_load ? link_valid[STEPS] : out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load && link_valid[STEPS]) begin
      if (link_vec[STEPS].fold) begin
        cosine_q <= $signed(-link_vec[STEPS].x);
        sine_q   <= $signed(-link_vec[STEPS].y);
      end else begin
        cosine_q <= $signed(link_vec[STEPS].x);
        sine_q   <= $signed(link_vec[STEPS].y);
      end
    end
  end

  assign out_o.valid  = out_valid_q;
  assign out_o.cosine = cosine_q;
  assign out_o.sine   = sine_q;

endmodule

/* design/cscos_checker.sv */
// Port-level checks for the CORDIC sine and cosine block, bound to the top level.
module cscos_port_checks
  import cscos_pkg::*;
(
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 in_valid_i,
  input logic                 in_ready_i,
  input logic                 out_valid_i,
  input logic                 out_ready_i,
  input logic signed [DW-1:0] cosine_i,
  input logic signed [DW-1:0] sine_i
);

  localparam logic signed [DW-1:0] LIMIT = 32'sh4100_0000;

  // A stalled result beat keeps its value.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(cosine_i) && $stable(sine_i))
    else $error("result changed while stalled");

  // With the output free to move, every stage moves, so the input must be ready.
  a_in_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!out_valid_i || out_ready_i) |-> in_ready_i)
    else $error("input not ready although the output register can drain");

  // Cosine stays close to the unit range.
  a_cos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (cosine_i <= LIMIT) && (cosine_i >= -LIMIT))
    else $error("cosine beyond unit magnitude");

  // Sine stays close to the unit range.
  a_sin_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (sine_i <= LIMIT) && (sine_i >= -LIMIT))
    else $error("sine beyond unit magnitude");

endmodule

bind cordic_sine_cosine cscos_port_checks u_cscos_port_checks (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .cosine_i    (out_o.cosine),
  .sine_i      (out_o.sine)
);

/* verif/cscos_checker.sv */
// Scoreboard for the CORDIC sine and cosine block: predicts each result and compares it.
`timescale 1ns / 100ps

module cscos_checker
  import cscos_pkg::*;
#(
  parameter int STEPS = 31
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  cscos_in_if   angle_ch,
  cscos_out_if  sincos_ch,
  output int    fail_count_o,
  output int    pending_o
);

  typedef struct packed {
    logic signed [DW-1:0] cosine;
    logic signed [DW-1:0] sine;
  } sincos_t;

  // Expected cosine and sine pairs, oldest first.
  sincos_t sincos_q[$];
  int      fails = 0;

  // Fold the angle into the right half plane, convert it to radians and rotate the gain vector.
  function automatic sincos_t compute_sincos(input logic signed [DW-1:0] ang);
    logic                 fold;
    logic signed [DW-1:0] a;
    logic signed [DW-1:0] vx;
    logic signed [DW-1:0] vy;
    logic signed [DW-1:0] dx;
    logic signed [DW-1:0] dy;
    longint               resid;
    sincos_t              r;
    fold = (ang > $signed(QUARTER_TURN)) || (ang < -$signed(QUARTER_TURN));
    a = fold ? ang + HALF_TURN : ang;
    // Radians in 2.30 format: the turn fraction times tau * 2^28, then down by 30 bits.
    resid = (longint'(a) * longint'(TAU_Q28)) >>> 30;
    vx = GAIN_K;
    vy = '0;
    for (int i = 0; i < STEPS; i++) begin
      dx = vy >>> i;
      dy = vx >>> i;
      if (resid >= 0) begin
        vx = vx - dx;
        vy = vy + dy;
        resid = resid - longint'(ATAN_TAB[i]);
      end else begin
        vx = vx + dx;
        vy = vy - dy;
        resid = resid + longint'(ATAN_TAB[i]);
      end
    end
    // A folded angle comes out of the opposite half plane.
    if (fold) begin
      vx = -vx;
      vy = -vy;
    end
    r.cosine = vx;
    r.sine   = vy;
    return r;
  endfunction

  // Record every accepted angle and check every accepted result against the oldest prediction.
  always @(posedge clk_i or negedge rst_ni) begin
    sincos_t want;
    if (!rst_ni) begin
      sincos_q.delete();
      fails = 0;
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      if (angle_ch.valid && angle_ch.ready) begin
        sincos_q.push_back(compute_sincos(angle_ch.angle));
      end
      if (sincos_ch.valid && sincos_ch.ready) begin
        if (sincos_q.size() == 0) begin
          $error("result beat with no angle outstanding: cosine %0d, sine %0d",
                 sincos_ch.cosine, sincos_ch.sine);
          fails++;
        end else begin
          want = sincos_q.pop_front();
          if (want.cosine !== sincos_ch.cosine) begin
            $error("cosine mismatch: expected %0d, actual %0d", want.cosine, sincos_ch.cosine);
            fails++;
          end
          if (want.sine !== sincos_ch.sine) begin
            $error("sine mismatch: expected %0d, actual %0d", want.sine, sincos_ch.sine);
            fails++;
          end
        end
      end
      fail_count_o <= fails;
      pending_o    <= sincos_q.size();
    end
  end

endmodule

/* verif/tb_cordic_sine_cosine.sv */
// Testbench top for the CORDIC sine and cosine block: clock, reset, angle stimulus and verdict.
`timescale 1ns / 100ps

module tb_cordic_sine_cosine;
  import cscos_pkg::*;

  localparam int     STEPS        = 31;
  localparam int     NUM_RANDOM   = 1750;
  localparam int     HOLD_CYCLES  = 200;
  localparam int     DRAIN_CYCLES = STEPS + 12;
  localparam longint CYCLE_LIMIT  = 400000;

  // Zero and neighbours, quarter and half turn edges, both extremes, octants and thirds of a turn.
  localparam logic [DW-1:0] DIRECTED [18] = '{
    32'h0000_0000, 32'h0000_0001, 32'hFFFF_FFFF, 32'h4000_0000, 32'hC000_0000,
    32'h4000_0001, 32'hBFFF_FFFF, 32'h3FFF_FFFF, 32'hC000_0001, 32'h7FFF_FFFF,
    32'h8000_0000, 32'h8000_0001, 32'h2000_0000, 32'hE000_0000, 32'h6000_0000,
    32'hA000_0000, 32'h5555_5555, 32'hAAAA_AAAA
  };

  logic   clk_i;
  logic   rst_ni;
  int     tx_idle_pct = 23;
  int     rx_idle_pct = 82;
  logic   hold_req    = 1'b0;
  int     fail_count;
  int     pending;
  longint cycles;

  cscos_in_if  angle_if ();
  cscos_out_if sincos_if ();

  cordic_sine_cosine #(
    .STEPS (STEPS)
  ) DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (angle_if),
    .out_o  (sincos_if)
  );

  cscos_checker #(
    .STEPS (STEPS)
  ) u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .angle_ch     (angle_if),
    .sincos_ch    (sincos_if),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Mostly full-range angles, the rest close to the fold edges, the half turn and zero.
  function automatic logic [DW-1:0] pick_angle();
    logic [DW-1:0] off;
    off = $urandom_range(64) - 32;
    case ($urandom_range(9))
      0, 1, 2, 3, 4, 5: return $urandom();
      6: return QUARTER_TURN + off;
      7: return -QUARTER_TURN + off;
      8: return HALF_TURN + off;
      default: return off;
    endcase
  endfunction

  // Offer one angle after a random gap and hold it until the block takes the beat.
  task automatic send_angle(input logic [DW-1:0] ang);
    while ($urandom_range(99) < tx_idle_pct) begin
      angle_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    angle_if.valid <= 1'b1;
    angle_if.angle <= ang;
    do @(posedge clk_i); while (!angle_if.ready);
  endtask

  // Result side: random stalls, plus one long hold-off when the last phase starts.
  initial begin
    logic hold_done;
    hold_done = 1'b0;
    sincos_if.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_req && !hold_done) begin
        sincos_if.ready <= 1'b0;
        hold_done = 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end else begin
        sincos_if.ready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  // Watchdog on the total run length.
  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("cordic_sine_cosine verification failed");
    $finish;
  end

  // Reset, directed angles, then three phases of random angles, drain and verdict.
  initial begin
    rst_ni         <= 1'b0;
    angle_if.valid <= 1'b0;
    angle_if.angle <= '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (DIRECTED[k]) begin
      send_angle(DIRECTED[k]);
    end

    for (int n = 0; n < NUM_RANDOM; n++) begin
      if (n == NUM_RANDOM / 3) begin
        tx_idle_pct = 82;
        rx_idle_pct <= 23;
      end else if (n == 2 * NUM_RANDOM / 3) begin
        tx_idle_pct = 0;
        rx_idle_pct <= 0;
        hold_req    <= 1'b1;
      end
      send_angle(pick_angle());
    end
    angle_if.valid <= 1'b0;

    // The outstanding count is registered, so it lags behind the last accepted beat.
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (fail_count == 0 && pending == 0) begin
      $display("cordic_sine_cosine verification clean");
    end else begin
      $display("cordic_sine_cosine verification failed");
    end
    $finish;
  end

endmodule

/* sim.f */
design/cscos_pkg.sv
design/cscos_in_if.sv
design/cscos_out_if.sv
design/cscos_prep.sv
design/cscos_cell.sv
design/cordic_sine_cosine.sv
design/cscos_checker.sv
verif/cscos_checker.sv
verif/tb_cordic_sine_cosine.sv
